// ===== src/eda_pkg.sv =====
// shared types and constants for the euclidean distance accumulator
// no dependencies; imported by eda_back and the top level
package eda_pkg;

    localparam int DIST_W = 24;
    localparam int SUM_W  = 48;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_CALC,
        BACK_HOLD
    } back_state_t;

endpackage

// ===== src/euclidean_distance_accumulator.sv =====
// euclidean distance accumulator: accepts one element pair per cycle (in_ready drops only
// while a finished vector sum waits for a full two-entry queue)
// after the last pair, a result passes front stages s1 and s2, the queue and the square
// root unit: one root bit per cycle, and no new sum is taken while a result waits
// reset (rst_n, async, active low) clears the running sum, overflow flag, queue and back fsm
// depends on eda_pkg, eda_front, eda_queue and eda_back
module euclidean_distance_accumulator
    import eda_pkg::*;
#(
    parameter int ELEM_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ELEM_WIDTH-1:0] first_elem,
    input  logic [ELEM_WIDTH-1:0] second_elem,
    input  logic                  last_elem,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic [DIST_W-1:0]     distance,
    output logic [SUM_W-1:0]      squared_sum,
    output logic                  saturated,
    output logic                  out_valid,
    input  logic                  out_ready
);

    logic                 push_valid;
    logic                 push_ready;
    logic [ACC_WIDTH-1:0] push_sum;
    logic                 push_sat;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [ACC_WIDTH-1:0] pop_sum;
    logic                 pop_sat;

    eda_front #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .first_elem  (first_elem),
        .second_elem (second_elem),
        .last_elem   (last_elem),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_sum    (push_sum),
        .push_sat    (push_sat)
    );

    eda_queue #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_sum   (push_sum),
        .push_sat   (push_sat),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_sum    (pop_sum),
        .pop_sat    (pop_sat)
    );

    eda_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_sum     (pop_sum),
        .pop_sat     (pop_sat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .distance    (distance),
        .squared_sum (squared_sum),
        .saturated   (saturated)
    );

endmodule

// ===== src/eda_front.sv =====
// front part: difference, square and saturating accumulation of element pairs
// pushes the finished sum and overflow flag of each vector into the queue
module eda_front #(
    parameter int ELEM_WIDTH = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ELEM_WIDTH-1:0] first_elem,
    input  logic [ELEM_WIDTH-1:0] second_elem,
    input  logic                  last_elem,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  push_valid,
    input  logic                  push_ready,
    output logic [ACC_WIDTH-1:0]  push_sum,
    output logic                  push_sat
);

    localparam int DIFF_W = ELEM_WIDTH + 1;
    localparam int SQ_W   = 2 * ELEM_WIDTH;
    localparam int EXT_W  = ((SQ_W > ACC_WIDTH) ? SQ_W : ACC_WIDTH) + 1;
    localparam logic [EXT_W-1:0] ACC_MAX_EXT =
        {{(EXT_W-ACC_WIDTH){1'b0}}, {ACC_WIDTH{1'b1}}};

    logic                  advance;
    logic                  s1_valid_reg;
    logic                  s1_last_reg;
    logic [ELEM_WIDTH-1:0] s1_mag_reg;
    logic                  s2_valid_reg;
    logic                  s2_last_reg;
    logic [SQ_W-1:0]       s2_sq_reg;
    logic [ACC_WIDTH-1:0]  sum_reg;
    logic [ACC_WIDTH-1:0]  sum_next;
    logic                  ovf_reg;
    logic                  ovf_next;

    logic signed [DIFF_W-1:0] diff;
    logic        [DIFF_W-1:0] diff_abs;
    logic        [EXT_W-1:0]  total;
    logic                     sat;

    // the pipeline only stalls when a vector end cannot enter the queue
    assign advance  = !(s2_valid_reg && s2_last_reg && !push_ready);
    assign in_ready = advance;

    assign diff     = $signed({first_elem[ELEM_WIDTH-1], first_elem})
                    - $signed({second_elem[ELEM_WIDTH-1], second_elem});
    assign diff_abs = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;

    assign total = EXT_W'(sum_reg) + EXT_W'(s2_sq_reg);
    assign sat   = total > ACC_MAX_EXT;

    always_comb
    begin
        sum_next = sat ? ACC_MAX_EXT[ACC_WIDTH-1:0] : total[ACC_WIDTH-1:0];
        ovf_next = ovf_reg | sat;
    end

    assign push_valid = s2_valid_reg && s2_last_reg;
    assign push_sum   = sum_next;
    assign push_sat   = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                if (s2_last_reg)
                begin
                    sum_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    ovf_reg <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_last_reg <= last_elem;
            s1_mag_reg  <= diff_abs[ELEM_WIDTH-1:0];
            s2_last_reg <= s1_last_reg;
            s2_sq_reg   <= s1_mag_reg * s1_mag_reg;
        end
    end

    // a stall is only ever caused by a waiting vector end
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s2_valid_reg && s2_last_reg && !push_ready))
        else $error("front stalled without a blocked vector end");

    // running sum is cleared after a vector end leaves
    a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready) |=> (sum_reg == '0 && !ovf_reg))
        else $error("running sum not cleared after vector end");

endmodule

// ===== src/eda_queue.sv =====
// two-entry queue of finished vector sums between front and back
// no package dependencies
module eda_queue #(
    parameter int ACC_WIDTH = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  logic [ACC_WIDTH-1:0] push_sum,
    input  logic                 push_sat,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output logic [ACC_WIDTH-1:0] pop_sum,
    output logic                 pop_sat
);

    localparam int DEPTH = 2;

    logic [ACC_WIDTH-1:0] sum_mem [DEPTH];
    logic                 sat_mem [DEPTH];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = count_reg != 2'(DEPTH);
    assign pop_valid  = count_reg != 2'd0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_sum    = sum_mem[rd_ptr_reg];
    assign pop_sat    = sat_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            sum_mem[wr_ptr_reg] <= push_sum;
            sat_mem[wr_ptr_reg] <= push_sat;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("queue count out of range");

    // pointers agree with the fill level
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg == rd_ptr_reg) == (count_reg == 2'd0 || count_reg == 2'(DEPTH)))
        else $error("queue pointers inconsistent with count");

endmodule

// ===== src/eda_back.sv =====
// back part: bit-pair iterative floor square root and output register
// depends on eda_pkg for the state type and output widths
module eda_back
    import eda_pkg::*;
#(
    parameter int ACC_WIDTH = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  logic [ACC_WIDTH-1:0] pop_sum,
    input  logic                 pop_sat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DIST_W-1:0]    distance,
    output logic [SUM_W-1:0]     squared_sum,
    output logic                 saturated
);

    localparam int N     = (ACC_WIDTH + 1) / 2;
    localparam int XW    = 2 * N;
    localparam int REM_W = N + 2;
    localparam int CNT_W = $clog2(N);

    back_state_t state_reg;
    back_state_t state_next;

    logic [XW-1:0]        x_reg;
    logic [N-1:0]         root_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [ACC_WIDTH-1:0] sum_reg;
    logic                 sat_reg;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;
    logic             ge;
    logic             load;
    logic             step;

    assign rem_shift = {rem_reg[REM_W-3:0], x_reg[XW-1:XW-2]};
    assign trial     = {root_reg, 2'b01};
    assign ge        = rem_shift >= trial;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BACK_IDLE:
                if (pop_valid)
                    state_next = BACK_CALC;
            BACK_CALC:
                if (cnt_reg == '0)
                    state_next = BACK_HOLD;
            BACK_HOLD:
                if (out_ready)
                    state_next = BACK_IDLE;
            default:
                state_next = BACK_IDLE;
        endcase
    end

    always_comb
    begin
        pop_ready = 1'b0;
        out_valid = 1'b0;
        step      = 1'b0;
        case (state_reg)
            BACK_IDLE: pop_ready = 1'b1;
            BACK_CALC: step      = 1'b1;
            BACK_HOLD: out_valid = 1'b1;
            default:   pop_ready = 1'b0;
        endcase
    end

    assign load = pop_ready && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                cnt_reg <= CNT_W'(N - 1);
            else if (step)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // two radicand bits enter the remainder each cycle of BACK_CALC, one root bit leaves
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= XW'(pop_sum);
            root_reg <= '0;
            rem_reg  <= '0;
            sum_reg  <= pop_sum;
            sat_reg  <= pop_sat;
        end
        else if (step)
        begin
            x_reg    <= {x_reg[XW-3:0], 2'b00};
            root_reg <= {root_reg[N-2:0], ge};
            rem_reg  <= ge ? (rem_shift - trial) : rem_shift;
        end
    end

    assign distance    = DIST_W'(root_reg);
    assign squared_sum = SUM_W'(sum_reg);
    assign saturated   = sat_reg;

    a_calc_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BACK_CALC && cnt_reg == '0) |=> state_reg == BACK_HOLD)
        else $error("square root did not finish on the last step");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !pop_ready)
        else $error("back took a new sum while a result waits");

endmodule
